// File: rtl/core/assert_macros.svh
// Assertion macros for the box blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, disabled while reset is high
`define AST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked assertion that also checks across reset
`define AST_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/core/bb_pkg.sv
// Shared types, constants and functions of the box blur block.
package bb_pkg;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam logic [11:0] IMG_W_RST = 12'd640;
   localparam logic [11:0] IMG_H_RST = 12'd480;
   localparam int FIFO_DEPTH = 4;

   localparam logic [7:0] CSR_IMAGE_WIDTH  = 8'd0;
   localparam logic [7:0] CSR_IMAGE_HEIGHT = 8'd1;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef logic [23:0] pixel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SHIFT,
      ST_SUM,
      ST_DIV
   } back_state_type;

   // ceil(2^16 / n); exact for sums below 2304
   function automatic logic [16:0] recip(input logic [1:0] rows, input logic [1:0] cols);
      logic [3:0] n;
      logic [16:0] m;
      n = 4'(rows) * 4'(cols);
      unique case (n)
         4'd1:    m = 17'd65536;
         4'd2:    m = 17'd32768;
         4'd3:    m = 17'd21846;
         4'd4:    m = 17'd16384;
         4'd6:    m = 17'd10923;
         4'd9:    m = 17'd7282;
         default: m = 17'd65536;
      endcase
      return m;
   endfunction
endpackage

// File: rtl/core/box_blur_3x3.sv
// Top level of the 3x3 box blur.
// Streaming 3x3 mean filter on 24-bit RGB pixels in raster order. The result
// for pixel k of a frame leaves with the input item number k + width + 1;
// after a frame's last pixel, send width + 1 drain items (or further pixels,
// whose data is ignored) to flush the held results; tlast marks the frame's
// final result. In the back end each item goes through queue pop, row store
// read, window shift and store write, sum and reciprocal multiply, and the
// next item is taken only once the last is through; an item without a
// result is done after the shift. A four-entry queue lets the input side
// keep accepting while the back end works, and the result register lets the
// next item start while a result waits. Writes to image_width or
// image_height restart the frame and must come while the block is idle.
module box_blur_3x3 #(
   parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // in_blue, in_green, in_red
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_blue, out_green, out_red
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [11:0] csr_data
);
   import bb_pkg::*;
   localparam int CW = $clog2(MAX_WIDTH);

   logic [11:0] width_ff, height_ff;
   logic [11:0] w_nz, eff_h;
   logic [CW:0] eff_w;
   logic        csr_acc, clear;
   logic        push, pop, fifo_full, fifo_empty;
   pixel_type   push_data, pop_data;

   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign clear     = csr_acc &&
                      (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   assign w_nz  = (width_ff == '0) ? 12'd1 : width_ff;
   assign eff_w = (int'(w_nz) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(w_nz);
   assign eff_h = (height_ff == '0) ? 12'd1 : height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMG_W_RST;
         height_ff <= IMG_H_RST;
      end else if (csr_acc) begin
         if (csr_index == CSR_IMAGE_WIDTH) width_ff <= csr_data;
         if (csr_index == CSR_IMAGE_HEIGHT) height_ff <= csr_data;
      end
   end

   bb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_data  (push_data)
   );

   bb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   bb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .fifo_empty (fifo_empty),
      .fifo_data  (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

// File: rtl/core/bb_fifo.sv
// Small item queue between the front and back parts.
module bb_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bb_pkg::pixel_type push_data,
   input  logic              pop,
   output bb_pkg::pixel_type pop_data,
   output logic              full,
   output logic              empty
);
   import bb_pkg::*;
   localparam int AW = $clog2(FIFO_DEPTH);

   pixel_type         mem_ff [FIFO_DEPTH];
   logic [AW-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]       cnt_ff, cnt_in;

   assign full     = (cnt_ff == (AW+1)'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end
endmodule

// File: rtl/core/bb_front.sv
// Front part: accepts items, drops early drains, tracks frame input position.
module bb_front #(
   parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF,
   localparam int CW = $clog2(MAX_WIDTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic [CW:0]       eff_w,
   input  logic [11:0]       eff_h,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   input  logic [23:0]       req_tdata,
   input  logic              fifo_full,
   output logic              push,
   output bb_pkg::pixel_type push_data
);
   import bb_pkg::*;

   logic [CW-1:0] col_ff, col_in;
   logic [11:0]   row_ff, row_in;
   logic [CW:0]   fcnt_ff, fcnt_in;
   logic          done;
   logic          acc;

   assign req_tready = !fifo_full;
   assign acc        = req_tvalid && req_tready;
   assign done       = (row_ff >= eff_h);
   assign push       = acc && (done || req_tuser == REQ_PIXEL);
   assign push_data  = done ? '0 : req_tdata;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      fcnt_in = fcnt_ff;
      if (clear) begin
         col_in  = '0;
         row_in  = '0;
         fcnt_in = '0;
      end else if (push) begin
         if (!done) begin
            if (((CW+1)'(col_ff) + 1'b1) >= eff_w) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end else if (fcnt_ff == eff_w) begin
            // last flush step ends the frame
            col_in  = '0;
            row_in  = '0;
            fcnt_in = '0;
         end else begin
            fcnt_in = fcnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         fcnt_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         fcnt_ff <= fcnt_in;
      end
   end
endmodule

// File: rtl/core/bb_back.sv
// Back part: row stores, 3x3 window, neighborhood sum and mean, result register.
`include "assert_macros.svh"
module bb_back #(
   parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF,
   localparam int CW = $clog2(MAX_WIDTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic [CW:0]       eff_w,
   input  logic [11:0]       eff_h,
   input  logic              fifo_empty,
   input  bb_pkg::pixel_type fifo_data,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,
   output logic              rsp_tlast
);
   import bb_pkg::*;

   back_state_type st_ff, st_in;

   pixel_type upper_mem [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];
   pixel_type top_q_ff, mid_q_ff;
   pixel_type pix_ff, pix_in;
   pixel_type win_ff [3][3];

   logic [CW-1:0] col_ff, col_in;
   logic [1:0]    rph_ff, rph_in;
   logic [CW-1:0] ocol_ff, ocol_in;
   logic [11:0]   orow_ff, orow_in;

   logic          emit, m_top, m_bot, m_left, m_right, last;
   logic          emit_ff, last_ff;
   logic [3:0]    mask_ff;
   logic [11:0]   sum_ff [3];
   logic [11:0]   sum_in [3];
   logic [16:0]   mul_ff;
   logic [1:0]    rows, cols;

   logic          out_free, load, do_shift;
   logic          rsp_tvalid_ff;
   logic [23:0]   rsp_tdata_ff, rsp_tdata_in;
   logic          rsp_tlast_ff;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (!fifo_empty) st_in = ST_FETCH;
         ST_FETCH: st_in = ST_SHIFT;
         ST_SHIFT: st_in = emit ? ST_SUM : ST_IDLE;
         ST_SUM:   st_in = ST_DIV;
         ST_DIV:   if (out_free) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop      = (st_ff == ST_IDLE) && !fifo_empty;
      do_shift = (st_ff == ST_SHIFT);
      load     = (st_ff == ST_DIV) && out_free;
   end

   assign emit    = (rph_ff == 2'd2) || (rph_ff == 2'd1 && col_ff != '0);
   assign m_top   = (orow_ff != '0);
   assign m_bot   = ({1'b0, orow_ff} + 13'd1) < {1'b0, eff_h};
   assign m_left  = (ocol_ff != '0);
   assign m_right = ((CW+1)'(ocol_ff) + 1'b1) < eff_w;
   assign last    = !m_bot && !m_right;
   assign pix_in  = pop ? fifo_data : pix_ff;

   always_comb begin
      col_in  = col_ff;
      rph_in  = rph_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (clear || (do_shift && emit && last)) begin
         col_in  = '0;
         rph_in  = '0;
         ocol_in = '0;
         orow_in = '0;
      end else if (do_shift) begin
         if (((CW+1)'(col_ff) + 1'b1) >= eff_w) begin
            col_in = '0;
            if (rph_ff != 2'd2) rph_in = rph_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
         if (emit) begin
            if (!m_right) begin
               ocol_in = '0;
               orow_in = orow_ff + 1'b1;
            end else begin
               ocol_in = ocol_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_in[k] = '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               if ((r != 0 || mask_ff[0]) && (r != 2 || mask_ff[1]) &&
                   (c != 0 || mask_ff[2]) && (c != 2 || mask_ff[3])) begin
                  sum_in[k] = sum_in[k] + 12'(win_ff[r][c][8*k +: 8]);
               end
            end
         end
      end
      rows = 2'd1 + 2'(mask_ff[0]) + 2'(mask_ff[1]);
      cols = 2'd1 + 2'(mask_ff[2]) + 2'(mask_ff[3]);
   end

   always_comb begin
      logic [28:0] prod;
      rsp_tdata_in = '0;
      for (int k = 0; k < 3; k++) begin
         prod = 29'(sum_ff[k]) * 29'(mul_ff);
         rsp_tdata_in[8*k +: 8] = prod[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         col_ff        <= '0;
         rph_ff        <= '0;
         ocol_ff       <= '0;
         orow_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) win_ff[r][c] <= '0;
         end
      end else begin
         st_ff   <= st_in;
         col_ff  <= col_in;
         rph_ff  <= rph_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
         if (load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (do_shift) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= top_q_ff;
            win_ff[1][2] <= mid_q_ff;
            win_ff[2][2] <= pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_q_ff <= upper_mem[col_ff];
      mid_q_ff <= middle_mem[col_ff];
      if (do_shift) begin
         upper_mem[col_ff]  <= mid_q_ff;
         middle_mem[col_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      if (do_shift) begin
         emit_ff <= emit;
         last_ff <= last;
         mask_ff <= {m_right, m_left, m_bot, m_top};
      end
      if (st_ff == ST_SUM) begin
         for (int k = 0; k < 3; k++) sum_ff[k] <= sum_in[k];
         mul_ff <= recip(rows, cols);
      end
      if (load) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tlast_ff <= last_ff;
      end
   end

   `AST(a_rsp_hold, clock, reset, rsp_tvalid_ff && !rsp_tready |=> rsp_tvalid_ff && $stable(rsp_tdata_ff), "result dropped while stalled")
   `AST(a_load_emit, clock, reset, load |-> emit_ff, "result loaded for a step without output")
   `AST(a_col_range, clock, reset, st_ff == ST_SHIFT |-> ({1'b0, col_ff} < eff_w), "store column out of range")
   `AST_NR(a_reset_idle, clock, reset |=> st_ff == ST_IDLE && !rsp_tvalid_ff, "not idle after reset")
endmodule

// File: bench/tb_box_blur_3x3.sv
// Self-checking testbench for the 3x3 box blur: random frames, drains and handshake gaps.
`timescale 1ns / 1ps

class blur_scoreboard;
   int unsigned img_w, img_h;
   logic [23:0] upper_row [2048];
   logic [23:0] middle_row [2048];
   logic [23:0] win [3][3];
   int unsigned in_col, in_row, out_col, out_row;
   logic [24:0] pending [$];
   int unsigned errors, checked;

   function new();
      img_w = 640;
      img_h = 480;
      foreach (upper_row[i]) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      restart();
      errors = 0;
      checked = 0;
   endfunction

   function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function int unsigned eff_w();
      if (img_w == 0) return 1;
      if (img_w > 2048) return 2048;
      return img_w;
   endfunction

   function int unsigned eff_h();
      return (img_h == 0) ? 1 : img_h;
   endfunction

   function void set_reg(logic [7:0] idx, logic [11:0] val);
      if (idx == bb_pkg::CSR_IMAGE_WIDTH) begin
         img_w = val;
         restart();
      end else if (idx == bb_pkg::CSR_IMAGE_HEIGHT) begin
         img_h = val;
         restart();
      end
   endfunction

   function bit frame_fed();
      return in_row >= eff_h();
   endfunction

   // notes one accepted input item, queues the blurred pixel it releases
   function void note_input(logic kind, logic [23:0] pix);
      int unsigned w, h, c, r, n;
      int unsigned sum [3];
      logic [23:0] v, res;
      bit last;
      w = eff_w();
      h = eff_h();
      if (!frame_fed() && kind == bb_pkg::REQ_DRAIN) return;
      if (frame_fed()) pix = '0;
      c = (in_col >= w) ? 0 : in_col;
      r = in_row;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = upper_row[c];
      win[1][2] = middle_row[c];
      win[2][2] = pix;
      upper_row[c] = middle_row[c];
      middle_row[c] = pix;
      if (c + 1 >= w) begin
         in_col = 0;
         in_row = r + 1;
      end else begin
         in_col = c + 1;
      end
      if (!(r >= 2 || (r == 1 && c >= 1))) return;
      sum = '{0, 0, 0};
      n = 0;
      for (int i = 0; i < 3; i++) begin
         if (i == 0 && out_row == 0) continue;
         if (i == 2 && out_row + 1 >= h) continue;
         for (int j = 0; j < 3; j++) begin
            if (j == 0 && out_col == 0) continue;
            if (j == 2 && out_col + 1 >= w) continue;
            v = win[i][j];
            for (int k = 0; k < 3; k++) sum[k] += v[8*k +: 8];
            n++;
         end
      end
      if (n == 0) n = 1;
      for (int k = 0; k < 3; k++) res[8*k +: 8] = 8'(sum[k] / n);
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      pending.push_back({last, res});
      if (last) restart();
      else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else out_col++;
   endfunction

   function void check_result(logic [23:0] data, logic tlast);
      logic [24:0] exp;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result %h last %b", data, tlast);
         return;
      end
      exp = pending.pop_front();
      if (exp[23:0] !== data || exp[24] !== tlast) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp %h last %b, got %h last %b", exp[23:0], exp[24], data, tlast);
      end
   endfunction
endclass

module tb_box_blur_3x3;
   import bb_pkg::*;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tuser = 0;
   logic [23:0] req_tdata = '0;
   logic req_tready, rsp_tvalid, rsp_tlast, csr_ready;
   logic rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic csr_valid = 0;
   logic [7:0] csr_index = '0;
   logic [11:0] csr_data = '0;

   blur_scoreboard blur_sb = new();
   int unsigned pixels_sent, frames_run;
   int unsigned rsp_gap;
   bit long_stalls;

   box_blur_3x3 DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int unsigned gap_len();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) blur_sb.check_result(rsp_tdata, rsp_tlast);
         if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_gap = long_stalls ? gap_len() : 0;
            rsp_tready <= 1;
         end
      end
   end

   task automatic send_item(logic kind, logic [23:0] pix);
      int unsigned gap;
      gap = long_stalls ? gap_len() : 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      blur_sb.note_input(kind, pix);
      if (kind == REQ_PIXEL) pixels_sent++;
   endtask

   task automatic wait_idle();
      int unsigned guard;
      req_tvalid <= 0;
      guard = 0;
      while (blur_sb.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [11:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      blur_sb.set_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [23:0] rand_pix();
      case ($urandom_range(5))
         0: return 24'hFFFFFF;
         1: return 24'h000000;
         default: return 24'($urandom);
      endcase
   endfunction

   // one frame, then drains (or junk pixels) until every result is released
   task automatic run_frame(int unsigned w, int unsigned h, bit extremes);
      int unsigned total;
      total = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(15) == 0) send_item(REQ_DRAIN, 24'($urandom));
         send_item(REQ_PIXEL, extremes ? ((i % 2) ? 24'hFFFFFF : 24'h0) : rand_pix());
      end
      while (blur_sb.frame_fed())
         send_item($urandom_range(3) == 0 ? REQ_PIXEL : REQ_DRAIN, 24'($urandom));
      frames_run++;
   endtask

   initial begin
      int unsigned w, h;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      long_stalls = 0;
      write_reg(CSR_IMAGE_WIDTH, 12'd1);
      write_reg(CSR_IMAGE_HEIGHT, 12'd1);
      run_frame(1, 1, 1);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 12'd3);
      write_reg(CSR_IMAGE_HEIGHT, 12'd3);
      run_frame(3, 3, 1);
      run_frame(3, 3, 0);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 12'd0);
      write_reg(CSR_IMAGE_HEIGHT, 12'd2);
      run_frame(0, 2, 0);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 12'd5);
      write_reg(CSR_IMAGE_HEIGHT, 12'd0);
      run_frame(5, 0, 0);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 12'd2);
      write_reg(CSR_IMAGE_HEIGHT, 12'd4095);
      // only part of this tall frame, then restart
      for (int i = 0; i < 12; i++) send_item(REQ_PIXEL, rand_pix());
      wait_idle();
      while (pixels_sent < 700) begin
         long_stalls = $urandom_range(2) != 0;
         w = $urandom_range(7, 1);
         h = $urandom_range(6, 1);
         if ($urandom_range(10) == 0) w = $urandom_range(40, 8);
         write_reg(CSR_IMAGE_WIDTH, 12'(w));
         write_reg(CSR_IMAGE_HEIGHT, 12'(h));
         repeat ($urandom_range(3, 1)) run_frame(w, h, 0);
         wait_idle();
      end
      wait_idle();
      $display("ran %0d frames, %0d pixels, %0d results checked",
               frames_run, pixels_sent, blur_sb.checked);
      $display("frames 1x1 to 40 wide, zero size registers, early drains, stalls both sides");
      if (blur_sb.errors == 0 && blur_sb.pending.size() == 0) $display("TB_OK");
      else begin
         $display("%0d mismatches, %0d results missing", blur_sb.errors,
                  blur_sb.pending.size());
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("TB_ERROR");
      $finish;
   end
endmodule
